[sv/fpa_pkg.sv]
// Shared constants, types and a helper function for the fixed-point ALU.
package fpa_pkg;

    localparam int FracBits = 8;
    localparam int DataW    = 32;
    localparam int MagW     = DataW;                 // operand magnitude width
    localparam int NumW     = MagW + FracBits + 1;   // 2*|a|*2^F plus |b|
    localparam int QuoW     = NumW;                  // quotient bits, one per cell
    localparam int PartW    = NumW + 1;              // partial remainder width
    localparam int DenW     = MagW + 1;              // 2*|b|
    localparam int NumCells = QuoW;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MAX     = 4'd10,
        OP_MIN     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } t_op;

    // Result that travels alongside the divider chain until the end.
    typedef struct packed {
        logic                    valid;
        logic                    is_div;
        logic                    neg;
        logic                    div_zero;
        logic signed [DataW-1:0] value;
        logic                    cmp;
        logic                    err;
    } t_side;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic logic [DataW:0] sat32(input logic signed [65:0] v);
        logic [DataW:0] res;
        begin
            if (v > 66'sd2147483647) begin
                res = {1'b1, 32'h7fff_ffff};
            end else if (v < -66'sd2147483648) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, v[DataW-1:0]};
            end
            return res;
        end
    endfunction

endpackage

[sv/fpa_div_cell.sv]
// One restoring-division cell: produces one quotient bit per item per cycle.
module fpa_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [fpa_pkg::PartW-1:0]    i_rem,
    input  logic [fpa_pkg::NumW-1:0]     i_num,
    input  logic [fpa_pkg::DenW-1:0]     i_den,
    input  logic [fpa_pkg::QuoW-1:0]     i_quo,
    output logic                         o_valid,
    output logic [fpa_pkg::PartW-1:0]    o_rem,
    output logic [fpa_pkg::NumW-1:0]     o_num,
    output logic [fpa_pkg::DenW-1:0]     o_den,
    output logic [fpa_pkg::QuoW-1:0]     o_quo
);
    logic                      r_valid;
    logic [fpa_pkg::PartW-1:0] r_rem, n_rem;
    logic [fpa_pkg::NumW-1:0]  r_num;
    logic [fpa_pkg::DenW-1:0]  r_den;
    logic [fpa_pkg::QuoW-1:0]  r_quo, n_quo;
    logic [fpa_pkg::PartW-1:0] shifted;
    logic [fpa_pkg::PartW:0]   diff;

    always_comb begin
        // Bring in the next numerator bit, then try to subtract the divisor.
        shifted = {i_rem[fpa_pkg::PartW-2:0], i_num[fpa_pkg::NumW-1]};
        diff    = {1'b0, shifted} - {{(fpa_pkg::PartW+1-fpa_pkg::DenW){1'b0}}, i_den};
        if (diff[fpa_pkg::PartW]) begin
            n_rem = shifted;
            n_quo = {i_quo[fpa_pkg::QuoW-2:0], 1'b0};
        end else begin
            n_rem = diff[fpa_pkg::PartW-1:0];
            n_quo = {i_quo[fpa_pkg::QuoW-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rem <= n_rem;
        r_num <= {i_num[fpa_pkg::NumW-2:0], 1'b0};
        r_den <= i_den;
        r_quo <= n_quo;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
endmodule

[sv/fpa_front.sv]
// Front stage: computes non-divide results and divider operands, all registered.
module fpa_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [3:0]                        i_action,
    input  logic signed [fpa_pkg::DataW-1:0]  i_a,
    input  logic signed [fpa_pkg::DataW-1:0]  i_b,
    output fpa_pkg::t_side                    o_side,
    output logic [fpa_pkg::NumW-1:0]          o_num,
    output logic [fpa_pkg::DenW-1:0]          o_den
);
    fpa_pkg::t_side                  r_side, n_side;
    logic [fpa_pkg::NumW-1:0]        r_num, n_num;
    logic [fpa_pkg::DenW-1:0]        r_den, n_den;
    logic [fpa_pkg::MagW-1:0]        mag_a, mag_b;
    logic [2*fpa_pkg::MagW-1:0]      prod;
    logic [2*fpa_pkg::MagW-1:0]      prod_rnd;
    logic signed [65:0]              wide;
    logic [fpa_pkg::DataW:0]         sat;
    logic                            neg;

    always_comb begin
        mag_a    = i_a[fpa_pkg::DataW-1] ? fpa_pkg::MagW'(-i_a) : fpa_pkg::MagW'(i_a);
        mag_b    = i_b[fpa_pkg::DataW-1] ? fpa_pkg::MagW'(-i_b) : fpa_pkg::MagW'(i_b);
        neg      = i_a[fpa_pkg::DataW-1] ^ i_b[fpa_pkg::DataW-1];
        prod     = mag_a * mag_b;
        prod_rnd = (prod + (2*fpa_pkg::MagW)'(1 << (fpa_pkg::FracBits - 1)))
                   >> fpa_pkg::FracBits;
        wide     = '0;
        n_side   = '0;
        n_side.valid = i_valid;
        n_side.neg   = neg;
        // Numerator 2*|a|*2^F + |b| and denominator 2*|b| round half away from zero.
        n_num = (fpa_pkg::NumW'(mag_a) << (fpa_pkg::FracBits + 1)) + fpa_pkg::NumW'(mag_b);
        n_den = {mag_b, 1'b0};
        unique case (fpa_pkg::t_op'(i_action))
            fpa_pkg::OP_ADD:  wide = 66'(i_a) + 66'(i_b);
            fpa_pkg::OP_SUB:  wide = 66'(i_a) - 66'(i_b);
            fpa_pkg::OP_MUL:  wide = neg ? -$signed({2'b00, prod_rnd})
                                         : $signed({2'b00, prod_rnd});
            fpa_pkg::OP_DIV: begin
                n_side.is_div   = 1'b1;
                n_side.div_zero = (i_b == '0);
            end
            fpa_pkg::OP_GT:   n_side.cmp = i_a > i_b;
            fpa_pkg::OP_LT:   n_side.cmp = i_a < i_b;
            fpa_pkg::OP_GE:   n_side.cmp = i_a >= i_b;
            fpa_pkg::OP_LE:   n_side.cmp = i_a <= i_b;
            fpa_pkg::OP_EQ:   n_side.cmp = i_a == i_b;
            fpa_pkg::OP_NE:   n_side.cmp = i_a != i_b;
            fpa_pkg::OP_MAX:  wide = (i_a >= i_b) ? 66'(i_a) : 66'(i_b);
            fpa_pkg::OP_MIN:  wide = (i_a <= i_b) ? 66'(i_a) : 66'(i_b);
            fpa_pkg::OP_INC:  wide = 66'(i_a) + 66'sd1;
            fpa_pkg::OP_DEC:  wide = 66'(i_a) - 66'sd1;
            fpa_pkg::OP_TOINT: wide = 66'(i_a >>> fpa_pkg::FracBits);
            fpa_pkg::OP_FROMINT: wide = 66'(i_a) <<< fpa_pkg::FracBits;
            default: wide = '0;
        endcase
        sat = fpa_pkg::sat32(wide);
        n_side.value = sat[fpa_pkg::DataW-1:0];
        n_side.err   = sat[fpa_pkg::DataW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= n_side;
        end
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_side = r_side;
    assign o_num  = r_num;
    assign o_den  = r_den;
endmodule

[sv/fixed_point_alu.sv]
// Top level of the fixed-point ALU: front stage, divider cell chain, output stage.
// Each result passes the front stage, one divider cell per quotient bit and then the
// output register on its way to the ports.
// Throughput: one item per cycle; busy stays low, and the divider chain sets latency.
// Reset: synchronous active-low i_rst_n clears all valid bits; items in flight are dropped.
module fixed_point_alu (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [3:0]                        i_action,
    input  logic signed [fpa_pkg::DataW-1:0]  i_operand_a,
    input  logic signed [fpa_pkg::DataW-1:0]  i_operand_b,
    output logic                              o_valid,
    output logic signed [fpa_pkg::DataW-1:0]  o_result_value,
    output logic                              o_compare_true,
    output logic                              o_error_flag
);
    localparam int N = fpa_pkg::NumCells;

    fpa_pkg::t_side             side_q [N+1];
    logic                       cv     [N+1];
    logic [fpa_pkg::PartW-1:0]  crem   [N+1];
    logic [fpa_pkg::NumW-1:0]   cnum   [N+1];
    logic [fpa_pkg::DenW-1:0]   cden   [N+1];
    logic [fpa_pkg::QuoW-1:0]   cquo   [N+1];

    logic                             r_valid;
    logic signed [fpa_pkg::DataW-1:0] r_value;
    logic                             r_cmp, r_err;
    logic signed [65:0]               wide;
    logic [fpa_pkg::DataW:0]          sat;
    fpa_pkg::t_side                   last;

    assign busy = 1'b0;

    fpa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_action (i_action),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .o_side   (side_q[0]),
        .o_num    (cnum[0]),
        .o_den    (cden[0])
    );

    assign cv[0]   = side_q[0].valid;
    assign crem[0] = '0;
    assign cquo[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cv[g]),
            .i_rem   (crem[g]),
            .i_num   (cnum[g]),
            .i_den   (cden[g]),
            .i_quo   (cquo[g]),
            .o_valid (cv[g+1]),
            .o_rem   (crem[g+1]),
            .o_num   (cnum[g+1]),
            .o_den   (cden[g+1]),
            .o_quo   (cquo[g+1])
        );
        // Side data rides along with the cell chain.
        fpa_pkg::t_side r_sd;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd <= '0;
            end else begin
                r_sd <= side_q[g];
            end
        end
        assign side_q[g+1] = r_sd;
    end

    always_comb begin
        last = side_q[N];
        wide = last.neg ? -$signed({1'b0, 24'd0, cquo[N]}) : $signed({1'b0, 24'd0, cquo[N]});
        sat  = fpa_pkg::sat32(wide);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= last.valid & cv[N];
        end
        r_cmp <= last.cmp;
        if (last.is_div) begin
            if (last.div_zero) begin
                r_value <= '0;
                r_err   <= 1'b1;
            end else begin
                r_value <= sat[fpa_pkg::DataW-1:0];
                r_err   <= sat[fpa_pkg::DataW];
            end
        end else begin
            r_value <= last.value;
            r_err   <= last.err;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_compare_true = r_cmp;
    assign o_error_flag   = r_err;
endmodule

[sv/fpa_checker.sv]
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [fpa_pkg::DataW-1:0]  o_result_value,
    input logic                              o_compare_true,
    input logic                              o_error_flag
);
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> o_result_value == '0)
        else $error("comparison with nonzero value");
    a_cmp_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> !o_error_flag)
        else $error("comparison with error");
    a_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");
    // Every accepted item produces its result, seen as o_valid after the delay in this property.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##43 o_valid)
        else $error("result missing after accepted item");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_result_value (o_result_value),
    .o_compare_true (o_compare_true),
    .o_error_flag   (o_error_flag)
);

[verif/tb_fixed_point_alu.sv]
// Self-checking testbench for the fixed-point ALU with directed items, random operands and random gaps.
module tb_fixed_point_alu;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        fpa_pkg::t_op                     op;
        logic signed [fpa_pkg::DataW-1:0] a;
        logic signed [fpa_pkg::DataW-1:0] b;
        int                               gap;
        bit                               drain;
    } t_item;

    typedef struct {
        logic signed [fpa_pkg::DataW-1:0] value;
        logic                             cmp;
        logic                             err;
    } t_alu_out;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic [3:0]                       i_action;
    logic signed [fpa_pkg::DataW-1:0] i_operand_a;
    logic signed [fpa_pkg::DataW-1:0] i_operand_b;
    logic                             o_valid;
    logic signed [fpa_pkg::DataW-1:0] o_result_value;
    logic                             o_compare_true;
    logic                             o_error_flag;

    t_item    pending_items[$];
    t_alu_out expected_outs[$];
    int       mismatch_count;
    bit       stimulus_done;
    int       gap_left;
    bit       holding;

    fixed_point_alu i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_valid       (o_valid),
        .o_result_value(o_result_value),
        .o_compare_true(o_compare_true),
        .o_error_flag  (o_error_flag)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic signed [fpa_pkg::DataW-1:0] clamp_to_word(
            input logic signed [71:0] v, inout logic err);
        if (v > 72'sd2147483647) begin
            err = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -72'sd2147483648) begin
            err = 1'b1;
            return 32'h8000_0000;
        end
        return v[fpa_pkg::DataW-1:0];
    endfunction

    // Exact arithmetic on wide signed values; products and quotients round half away from zero.
    function automatic t_alu_out alu_result(input fpa_pkg::t_op op,
                                            input logic signed [fpa_pkg::DataW-1:0] a,
                                            input logic signed [fpa_pkg::DataW-1:0] b);
        t_alu_out          res;
        logic signed [71:0] wa;
        logic signed [71:0] wb;
        logic [71:0]        ma;
        logic [71:0]        mb;
        logic [71:0]        q;
        logic               neg;
        logic               err;
        wa = a;
        wb = b;
        ma = (wa < 0) ? -wa : wa;
        mb = (wb < 0) ? -wb : wb;
        neg = (wa < 0) != (wb < 0);
        err = 1'b0;
        res.value = '0;
        res.cmp = 1'b0;
        case (op)
            fpa_pkg::OP_ADD: res.value = clamp_to_word(wa + wb, err);
            fpa_pkg::OP_SUB: res.value = clamp_to_word(wa - wb, err);
            fpa_pkg::OP_MUL: begin
                q = (ma * mb + (72'd1 << (fpa_pkg::FracBits - 1))) >> fpa_pkg::FracBits;
                res.value = clamp_to_word(neg ? -$signed(q) : $signed(q), err);
            end
            fpa_pkg::OP_DIV: begin
                if (b == 0) begin
                    err = 1'b1;
                end else begin
                    q = (2 * (ma << fpa_pkg::FracBits) + mb) / (2 * mb);
                    res.value = clamp_to_word(neg ? -$signed(q) : $signed(q), err);
                end
            end
            fpa_pkg::OP_GT: res.cmp = a > b;
            fpa_pkg::OP_LT: res.cmp = a < b;
            fpa_pkg::OP_GE: res.cmp = a >= b;
            fpa_pkg::OP_LE: res.cmp = a <= b;
            fpa_pkg::OP_EQ: res.cmp = a == b;
            fpa_pkg::OP_NE: res.cmp = a != b;
            fpa_pkg::OP_MAX: res.value = (a >= b) ? a : b;
            fpa_pkg::OP_MIN: res.value = (a <= b) ? a : b;
            fpa_pkg::OP_INC: res.value = clamp_to_word(wa + 1, err);
            fpa_pkg::OP_DEC: res.value = clamp_to_word(wa - 1, err);
            fpa_pkg::OP_TOINT: res.value = a >>> fpa_pkg::FracBits;
            default: res.value = clamp_to_word(wa * (72'sd1 <<< fpa_pkg::FracBits), err);
        endcase
        res.err = err;
        return res;
    endfunction

    function automatic logic signed [fpa_pkg::DataW-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff - $urandom_range(0, 3);
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 4095)) - 2048;
            3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input fpa_pkg::t_op op,
                            input logic signed [fpa_pkg::DataW-1:0] a,
                            input logic signed [fpa_pkg::DataW-1:0] b, input bit drain);
        t_item it;
        it.op = op;
        it.a = a;
        it.b = b;
        it.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        it.drain = drain;
        pending_items.push_back(it);
    endtask

    // Driver: inputs change on the falling edge only.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // Hold the offered item until it is taken.
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (holding && expected_outs.size() != 0) begin
            start <= 1'b0;
        end else if (pending_items.size() != 0 && !(start && pending_items[0].gap > 0)) begin
            t_item it;
            it = pending_items.pop_front();
            start <= 1'b1;
            i_action <= it.op;
            i_operand_a <= it.a;
            i_operand_b <= it.b;
            if (pending_items.size() != 0) begin
                gap_left <= pending_items[0].gap;
                holding <= pending_items[0].drain;
            end else begin
                holding <= 1'b0;
            end
        end else begin
            start <= 1'b0;
            if (pending_items.size() == 0) begin
                stimulus_done <= start ? 1'b0 : 1'b1;
            end else begin
                gap_left <= pending_items[0].gap - 1;
                pending_items[0].gap = 0;
            end
        end
    end

    // Monitor: accepted items feed the predictor, results are checked on rising edges.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_outs.push_back(alu_result(fpa_pkg::t_op'(i_action), i_operand_a,
                                                   i_operand_b));
            end
            if (o_valid) begin
                if (expected_outs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected result %h", o_result_value);
                    end
                end else begin
                    t_alu_out exp_out;
                    exp_out = expected_outs.pop_front();
                    if (exp_out.value !== o_result_value || exp_out.cmp !== o_compare_true
                            || exp_out.err !== o_error_flag) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     exp_out.value, exp_out.cmp, exp_out.err,
                                     o_result_value, o_compare_true, o_error_flag);
                        end
                    end
                end
            end
        end
    end

    initial begin
        logic signed [fpa_pkg::DataW-1:0] max_v;
        logic signed [fpa_pkg::DataW-1:0] min_v;
        max_v = 32'sh7fff_ffff;
        min_v = 32'sh8000_0000;
        start = 1'b0;
        i_action = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        mismatch_count = 0;
        stimulus_done = 1'b0;
        gap_left = 0;
        holding = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: bounds, saturation, rounding ties and division by zero.
        add_item(fpa_pkg::OP_ADD, max_v, 1, 0);
        add_item(fpa_pkg::OP_SUB, min_v, 1, 0);
        add_item(fpa_pkg::OP_MUL, max_v, max_v, 0);
        add_item(fpa_pkg::OP_MUL, min_v, max_v, 0);
        add_item(fpa_pkg::OP_MUL, 32'sd1, 32'sd128, 0);
        add_item(fpa_pkg::OP_MUL, -32'sd1, 32'sd128, 0);
        add_item(fpa_pkg::OP_DIV, 32'sd256, 32'sd0, 0);
        add_item(fpa_pkg::OP_DIV, max_v, 32'sd1, 0);
        add_item(fpa_pkg::OP_DIV, min_v, -32'sd1, 0);
        add_item(fpa_pkg::OP_DIV, 32'sd1, -32'sd512, 0);
        add_item(fpa_pkg::OP_GT, min_v, max_v, 0);
        add_item(fpa_pkg::OP_LT, min_v, max_v, 0);
        add_item(fpa_pkg::OP_GE, 32'sd5, 32'sd5, 0);
        add_item(fpa_pkg::OP_LE, 32'sd5, 32'sd5, 0);
        add_item(fpa_pkg::OP_EQ, max_v, max_v, 0);
        add_item(fpa_pkg::OP_NE, max_v, min_v, 0);
        add_item(fpa_pkg::OP_MAX, min_v, max_v, 0);
        add_item(fpa_pkg::OP_MIN, min_v, max_v, 0);
        add_item(fpa_pkg::OP_INC, max_v, 0, 0);
        add_item(fpa_pkg::OP_DEC, min_v, 0, 0);
        add_item(fpa_pkg::OP_TOINT, -32'sd1, 0, 0);
        add_item(fpa_pkg::OP_TOINT, min_v, 0, 0);
        add_item(fpa_pkg::OP_FROMINT, max_v, 0, 0);
        add_item(fpa_pkg::OP_FROMINT, min_v, 0, 0);
        add_item(fpa_pkg::OP_ADD, 32'sd0, 32'sd0, 1);

        for (int n = 0; n < 1150; n++) begin
            add_item(fpa_pkg::t_op'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                     n % 400 == 399);
        end
        wait (stimulus_done && expected_outs.size() == 0);
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && expected_outs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
